// File: hw/rtl/dwmf_pkg.sv
`timescale 1ns / 1ps
package dwmf_pkg;

	// history depth and position counter width
	localparam int MAX_WINDOW    = 16;
	localparam int POSITION_BITS = 24;

	// field widths
	localparam int LETTER_W  = 5;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int WIN_W     = $clog2(MAX_WINDOW + 1);

	// stream word widths, padded to whole bytes
	localparam int IN_DATA_W  = ((LETTER_W + 7) / 8) * 8;
	localparam int OUT_BITS   = POSITION_BITS + 2;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [POSITION_BITS-1:0] POSITION_MAX = {POSITION_BITS{1'b1}};

	// register reset values
	localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = CFG_W'(4);
	localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = CFG_W'(14);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_WINDOW = 2'd0,
		REG_LONG_WINDOW  = 2'd1
	} cfg_reg_e;

	typedef logic [LETTER_W-1:0] letter_t;

	// one result word
	typedef struct packed {
		logic                     long_marker;
		logic                     short_marker;
		logic [POSITION_BITS-1:0] position;
	} result_t;

	// zero reads as one, anything above the history depth as the full depth
	function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_W-1:0] w);
		logic [WIN_W-1:0] r;
		if (w == '0) begin
			r = WIN_W'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = WIN_W'(MAX_WINDOW);
		end else begin
			r = WIN_W'(w);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/dwmf_distinct.sv
`timescale 1ns / 1ps
module dwmf_distinct (
	input  dwmf_pkg::letter_t          hist [dwmf_pkg::MAX_WINDOW],
	input  logic [dwmf_pkg::WIN_W-1:0] short_win,
	input  logic [dwmf_pkg::WIN_W-1:0] long_win,
	output logic                       short_ok,
	output logic                       long_ok
);
	import dwmf_pkg::*;

	logic [MAX_WINDOW-1:0] dup;
	logic [MAX_WINDOW-1:0] short_mask;
	logic [MAX_WINDOW-1:0] long_mask;

	// pairwise compare: entry j repeats some newer entry
	always_comb begin
		dup = '0;
		for (int j = 1; j < MAX_WINDOW; j++) begin
			for (int i = 0; i < j; i++) begin
				if (hist[i] == hist[j]) begin
					dup[j] = 1'b1;
				end
			end
		end
	end

	// window masks over the newest entries
	always_comb begin
		for (int j = 0; j < MAX_WINDOW; j++) begin
			short_mask[j] = (j < int'(short_win));
			long_mask[j]  = (j < int'(long_win));
		end
	end

	assign short_ok = ~|(dup & short_mask);
	assign long_ok  = ~|(dup & long_mask);

endmodule

// File: hw/rtl/dwmf_track.sv
`timescale 1ns / 1ps
module dwmf_track (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  dwmf_pkg::letter_t              letter,
	input  logic                           stream_start,
	input  logic                           cfg_we,
	input  logic [dwmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dwmf_pkg::CFG_W-1:0]     cfg_data,
	output dwmf_pkg::result_t              res
);
	import dwmf_pkg::*;

	letter_t                hist_q [MAX_WINDOW];
	letter_t                hist_next [MAX_WINDOW];
	logic [POSITION_BITS-1:0] count_q;
	logic [POSITION_BITS-1:0] count_next;
	logic                   short_seen_q;
	logic                   long_seen_q;
	logic                   short_base;
	logic                   long_base;
	logic [CFG_W-1:0]       short_window_q;
	logic [CFG_W-1:0]       long_window_q;
	logic [WIN_W-1:0]       short_win;
	logic [WIN_W-1:0]       long_win;
	logic                   short_ok;
	logic                   long_ok;
	logic                   short_fire;
	logic                   long_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= SHORT_WINDOW_RST;
			long_window_q  <= LONG_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHORT_WINDOW: short_window_q <= cfg_data;
				REG_LONG_WINDOW:  long_window_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign short_win = clamp_window(short_window_q);
	assign long_win  = clamp_window(long_window_q);

	// shifted history with the new letter at the front
	always_comb begin
		hist_next[0] = letter;
		for (int i = 1; i < MAX_WINDOW; i++) begin
			hist_next[i] = hist_q[i-1];
		end
	end

	// saturating position, restarted by a stream start
	always_comb begin
		if (stream_start) begin
			count_next = POSITION_BITS'(1);
		end else if (count_q == POSITION_MAX) begin
			count_next = POSITION_MAX;
		end else begin
			count_next = count_q + POSITION_BITS'(1);
		end
	end

	dwmf_distinct u_distinct (
		.hist      (hist_next),
		.short_win (short_win),
		.long_win  (long_win),
		.short_ok  (short_ok),
		.long_ok   (long_ok)
	);

	// first distinct window once the window has filled
	assign short_base = stream_start ? 1'b0 : short_seen_q;
	assign long_base  = stream_start ? 1'b0 : long_seen_q;
	assign short_fire = !short_base && (count_next >= POSITION_BITS'(short_win)) && short_ok;
	assign long_fire  = !long_base && (count_next >= POSITION_BITS'(long_win)) && long_ok;

	// stream state, advanced on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			short_seen_q <= 1'b0;
			long_seen_q  <= 1'b0;
			for (int i = 0; i < MAX_WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else if (accept) begin
			count_q      <= count_next;
			short_seen_q <= short_base | short_fire;
			long_seen_q  <= long_base | long_fire;
			hist_q       <= hist_next;
		end
	end

	assign res.position     = count_next;
	assign res.short_marker = short_fire;
	assign res.long_marker  = long_fire;

endmodule

// File: hw/rtl/distinct_window_marker_finder.sv
`timescale 1ns / 1ps
// channel | direction | tdata                              | tuser
// s_      | in        | letter                             | stream_start
// m_      | out       | position, short_marker, long_marker | -
// cfg_    | in        | write data (window length)         | -
//
// one word in and one word out per cycle unless stalled; a result shows in the cycle
// after its word is taken, set by the single output register after the compare network
// reset clears the history, position, seen flags and output valid; windows go to 4 and 14
// s_tready drops only while a result waits and m_tready is low
module distinct_window_marker_finder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dwmf_pkg::IN_DATA_W-1:0]  s_tdata,  // letter
	input  logic [0:0]                      s_tuser,  // stream_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dwmf_pkg::OUT_DATA_W-1:0] m_tdata,  // position, short_marker, long_marker
	input  logic                            cfg_we,
	input  logic [dwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dwmf_pkg::CFG_W-1:0]      cfg_data
);
	import dwmf_pkg::*;

	logic                  accept;
	result_t               res;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	dwmf_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.letter       (s_tdata[LETTER_W-1:0]),
		.stream_start (s_tuser[0]),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.res          (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_DATA_W'(res);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: hw/rtl/dwmf_checker.sv
`timescale 1ns / 1ps
module dwmf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [0:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dwmf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dwmf_pkg::*;

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// every accepted word gives a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word gave no result");

	// a waiting result blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("word accepted over a waiting result");

	// a stream start restarts the position at one
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=>
			m_tdata[POSITION_BITS-1:0] == POSITION_BITS'(1))
		else $error("position not restarted by stream start");

	// a marker never shows on position zero
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[POSITION_BITS] || m_tdata[POSITION_BITS+1]) |->
			m_tdata[POSITION_BITS-1:0] != '0)
		else $error("marker on position zero");

endmodule

bind distinct_window_marker_finder dwmf_checker u_dwmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
